// ===== hdl/skl_pkg.sv =====
`default_nettype none

package skl_pkg;

  // Default number of records the list can hold.
  localparam int CAPACITY_DEF = 64;

  // One stored record is the key in the upper half and the payload in the lower half.
  localparam int REC_W = 64;

  localparam logic [2:0] OP_INS_HEAD = 3'd0;
  localparam logic [2:0] OP_INS_TAIL = 3'd1;
  localparam logic [2:0] OP_INS_ORD  = 3'd2;
  localparam logic [2:0] OP_RM_HEAD  = 3'd3;
  localparam logic [2:0] OP_RM_TAIL  = 3'd4;
  localparam logic [2:0] OP_RM_KEY   = 3'd5;
  localparam logic [2:0] OP_READ_POS = 3'd6;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] entry_key;
    logic [31:0]        entry_payload;
    logic [6:0]         position;
  } in_word_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_key;
    logic [31:0]        read_payload;
    logic [6:0]         count;
    logic               is_empty;
    logic               is_full;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hdl/sequential_keyed_list.sv =====
// A read by position passes through S_RD, S_RDW and S_DONE; a tail insert or tail remove
// passes through S_UP or S_DOWN and then S_DONE. Searches and shifts walk the records one at
// a time through the single RAM port pair.
// Throughput: one word at a time; the next input word is taken once the result is registered.
// Reset (rst_n low, synchronous) empties the list and clears all handshake state; the record
// RAM is not cleared, since only slots below the record count are ever used.
`default_nettype none

module sequential_keyed_list #(
  parameter int CAPACITY = skl_pkg::CAPACITY_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire skl_pkg::in_word_t    in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output skl_pkg::out_word_t        out_word
);

  // Address width for the record RAM and count width able to hold CAPACITY itself.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = skl_pkg::REC_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for an input word
  localparam logic [2:0] S_SEARCH = 3'd1;  // scanning records from slot zero
  localparam logic [2:0] S_UP     = 3'd2;  // opening a gap, then writing the new record
  localparam logic [2:0] S_DOWN   = 3'd3;  // closing a gap, then shrinking the list
  localparam logic [2:0] S_RD     = 3'd4;  // read address issued for a positional read
  localparam logic [2:0] S_RDW    = 3'd5;  // positional read data available
  localparam logic [2:0] S_DONE   = 3'd6;  // result ready to move into the output register

  logic [2:0]          state_r, state_nxt;
  logic [2:0]          op_r, op_nxt;
  logic signed [31:0]  key_r, key_nxt;
  logic [31:0]         pay_r, pay_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       scan_r, scan_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [AW-1:0]       src_r, src_nxt;
  logic [AW-1:0]       lo_r, lo_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       pend_idx_r, pend_idx_nxt;
  logic                ok_r, ok_nxt;
  logic signed [31:0]  rk_r, rk_nxt;
  logic [31:0]         rp_r, rp_nxt;
  logic                out_valid_r, out_valid_nxt;
  skl_pkg::out_word_t  out_word_r, out_word_nxt;

  // Record RAM port signals.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [RW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [RW-1:0]       ram_rdata;
  logic signed [31:0]  rd_key;

  logic                accept;
  logic                is_full_now;
  logic                is_empty_now;
  logic                pos_ok;
  logic                hit;
  logic                last;
  logic                out_free;

  skl_ram #(
    .WIDTH (RW),
    .DEPTH (CAPACITY)
  ) u_records (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key = $signed(ram_rdata[RW-1:32]);

  // The input side is held off whenever an operation is in progress. A finished result
  // waiting in the output register does not hold off the next word.
  assign in_stall     = (state_r != S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign is_full_now  = (count_r == CW'(CAPACITY));
  assign is_empty_now = (count_r == '0);
  assign pos_ok       = (in_word.position != 7'd0) &&
                        (32'(in_word.position) <= 32'(count_r));
  assign out_free     = !out_valid_r || !out_stall;

  // During a search the compare works on the word read in the previous cycle. An ordered
  // insert stops at the first key that is not below the new key; a remove by key stops at
  // the first equal key.
  assign hit  = pend_r && ((op_r == skl_pkg::OP_INS_ORD) ? !(rd_key < key_r) : (rd_key == key_r));
  assign last = pend_r && (pend_idx_r == AW'(count_r - CW'(1)));

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    n_nxt         = n_r;
    src_nxt       = src_r;
    lo_nxt        = lo_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    ok_nxt        = ok_r;
    rk_nxt        = rk_r;
    rp_nxt        = rp_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = ram_rdata;
    ram_raddr     = src_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = in_word.op;
          key_nxt = in_word.entry_key;
          pay_nxt = in_word.entry_payload;
          ok_nxt  = 1'b0;
          rk_nxt  = '0;
          rp_nxt  = '0;
          scan_nxt = '0;
          n_nxt    = '0;
          lo_nxt   = '0;
          state_nxt = S_DONE;
          case (in_word.op)
            skl_pkg::OP_INS_HEAD: begin
              if (!is_full_now) begin
                // Move every record up by one, starting from the top.
                n_nxt     = count_r;
                src_nxt   = AW'(count_r - CW'(1));
                state_nxt = S_UP;
              end
            end
            skl_pkg::OP_INS_TAIL: begin
              if (!is_full_now) begin
                lo_nxt    = AW'(count_r);
                state_nxt = S_UP;
              end
            end
            skl_pkg::OP_INS_ORD: begin
              if (!is_full_now) begin
                state_nxt = is_empty_now ? S_UP : S_SEARCH;
              end
            end
            skl_pkg::OP_RM_HEAD: begin
              if (!is_empty_now) begin
                n_nxt     = count_r - CW'(1);
                src_nxt   = AW'(1);
                state_nxt = S_DOWN;
              end
            end
            skl_pkg::OP_RM_TAIL: begin
              if (!is_empty_now) begin
                state_nxt = S_DOWN;
              end
            end
            skl_pkg::OP_RM_KEY: begin
              if (!is_empty_now) begin
                state_nxt = S_SEARCH;
              end
            end
            skl_pkg::OP_READ_POS: begin
              if (pos_ok) begin
                src_nxt   = AW'(in_word.position - 7'd1);
                state_nxt = S_RD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SEARCH: begin
        ram_raddr = scan_r[AW-1:0];
        if (hit) begin
          if (op_r == skl_pkg::OP_INS_ORD) begin
            lo_nxt    = pend_idx_r;
            n_nxt     = count_r - CW'(pend_idx_r);
            src_nxt   = AW'(count_r - CW'(1));
            state_nxt = S_UP;
          end else begin
            n_nxt     = count_r - CW'(1) - CW'(pend_idx_r);
            src_nxt   = pend_idx_r + AW'(1);
            state_nxt = S_DOWN;
          end
        end else if (last) begin
          if (op_r == skl_pkg::OP_INS_ORD) begin
            // Every key is below the new one: it goes at the end.
            lo_nxt    = AW'(count_r);
            n_nxt     = '0;
            state_nxt = S_UP;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (scan_r < count_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_r[AW-1:0];
          scan_nxt     = scan_r + CW'(1);
        end
      end

      S_UP: begin
        // Reads walk downward; each word read is written one slot higher in the next cycle.
        if (n_r != '0) begin
          ram_raddr    = src_r;
          pend_nxt     = 1'b1;
          pend_idx_nxt = src_r;
          src_nxt      = src_r - AW'(1);
          n_nxt        = n_r - CW'(1);
        end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_r + AW'(1);
          ram_wdata = ram_rdata;
        end else if (n_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = lo_r;
          ram_wdata = {key_r, pay_r};
          count_nxt = count_r + CW'(1);
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_DOWN: begin
        // Reads walk upward; each word read is written one slot lower in the next cycle.
        if (n_r != '0) begin
          ram_raddr    = src_r;
          pend_nxt     = 1'b1;
          pend_idx_nxt = src_r;
          src_nxt      = src_r + AW'(1);
          n_nxt        = n_r - CW'(1);
        end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_r - AW'(1);
          ram_wdata = ram_rdata;
        end else if (n_r == '0) begin
          count_nxt = count_r - CW'(1);
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_RD: begin
        ram_raddr = src_r;
        state_nxt = S_RDW;
      end

      S_RDW: begin
        rk_nxt    = rd_key;
        rp_nxt    = ram_rdata[31:0];
        ok_nxt    = 1'b1;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.ok           = ok_r;
          out_word_nxt.read_key     = rk_r;
          out_word_nxt.read_payload = rp_r;
          out_word_nxt.count        = 7'(count_r);
          out_word_nxt.is_empty     = (count_r == '0);
          out_word_nxt.is_full      = (count_r == CW'(CAPACITY));
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Operation payload and walk pointers need no reset.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    scan_r     <= scan_nxt;
    n_r        <= n_nxt;
    src_r      <= src_nxt;
    lo_r       <= lo_nxt;
    pend_idx_r <= pend_idx_nxt;
    ok_r       <= ok_nxt;
    rk_r       <= rk_nxt;
    rp_r       <= rp_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef NO_ASSERTIONS
  // The record count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("record count above capacity");

  // The record RAM is written only while a gap is opened or closed or a new record is stored.
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_UP || state_r == S_DOWN))
    else $error("record write outside a shift phase");

  // The count does not move while the sequencer is idle.
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |=> $stable(count_r))
    else $error("record count changed while idle");

  // A failed operation reports a zero record.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.ok) |->
      (out_word_r.read_key == '0 && out_word_r.read_payload == '0))
    else $error("failed operation reported a record");
`endif

endmodule

`default_nettype wire

// ===== hdl/skl_ram.sv =====
`default_nettype none

module skl_ram #(
  parameter int WIDTH = skl_pkg::REC_W,
  parameter int DEPTH = skl_pkg::CAPACITY_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== dv/sequential_keyed_list_test.sv =====
`timescale 1ns / 100ps

module sequential_keyed_list_test;

  localparam int CAPACITY = skl_pkg::CAPACITY_DEF;

  // Op code 7 has no operation behind it. The block must answer it as a failed operation.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  // The worst operation walks the whole list once; the drain wait leaves margin beyond that.
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;
  localparam int RANDOM_WORDS = 700;

  typedef enum int {GROW, SHRINK, CHURN} phase_kind_t;

  // The tracker keeps a model of the list contents. Each accepted request updates that
  // model and queues the response word the block must return. Responses are compared
  // in order against that queue.
  class keyed_list_tracker;
    logic signed [31:0]  keys [CAPACITY];
    logic [31:0]         payloads [CAPACITY];
    int unsigned         n;
    skl_pkg::out_word_t  expected_words [$];
    int                  fails;

    function void open_slot(int unsigned at);
      for (int unsigned k = n; k > at; k--) begin
        keys[k]     = keys[k - 1];
        payloads[k] = payloads[k - 1];
      end
    endfunction

    function void close_slot(int unsigned at);
      for (int unsigned k = at; k + 1 < n; k++) begin
        keys[k]     = keys[k + 1];
        payloads[k] = payloads[k + 1];
      end
    endfunction

    function void place(int unsigned at, skl_pkg::in_word_t w);
      open_slot(at);
      keys[at]     = w.entry_key;
      payloads[at] = w.entry_payload;
      n++;
    endfunction

    function void apply_request(skl_pkg::in_word_t w);
      skl_pkg::out_word_t r;
      int unsigned        i;
      r = '0;
      case (w.op)
        skl_pkg::OP_INS_HEAD, skl_pkg::OP_INS_TAIL, skl_pkg::OP_INS_ORD: begin
          if (n < CAPACITY) begin
            i = 0;
            if (w.op == skl_pkg::OP_INS_TAIL) begin
              i = n;
            end else if (w.op == skl_pkg::OP_INS_ORD) begin
              // The new record lands in front of the first key that is not smaller.
              while (i < n && keys[i] < w.entry_key) i++;
            end
            place(i, w);
            r.ok = 1'b1;
          end
        end
        skl_pkg::OP_RM_HEAD, skl_pkg::OP_RM_TAIL: begin
          if (n > 0) begin
            if (w.op == skl_pkg::OP_RM_HEAD) close_slot(0);
            n--;
            r.ok = 1'b1;
          end
        end
        skl_pkg::OP_RM_KEY: begin
          i = 0;
          while (i < n && keys[i] != w.entry_key) i++;
          if (i < n) begin
            close_slot(i);
            n--;
            r.ok = 1'b1;
          end
        end
        skl_pkg::OP_READ_POS: begin
          if (w.position >= 1 && w.position <= n) begin
            r.read_key     = keys[w.position - 1];
            r.read_payload = payloads[w.position - 1];
            r.ok           = 1'b1;
          end
        end
        default: ;
      endcase
      r.count    = n[6:0];
      r.is_empty = (n == 0);
      r.is_full  = (n == CAPACITY);
      expected_words.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        fails++;
      end
    endfunction

    function void check_response(skl_pkg::out_word_t got);
      skl_pkg::out_word_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: response word with nothing pending, actual %p", $time, got);
        fails++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("ok", want.ok, got.ok);
      compare_field("read_key", want.read_key, got.read_key);
      compare_field("read_payload", want.read_payload, got.read_payload);
      compare_field("count", want.count, got.count);
      compare_field("is_empty", want.is_empty, got.is_empty);
      compare_field("is_full", want.is_full, got.is_full);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  skl_pkg::in_word_t   in_word;
  logic                out_valid;
  logic                out_stall;
  skl_pkg::out_word_t  out_word;

  keyed_list_tracker list_model = new;

  // Each side runs idle-free for a stretch now and then; these count down those stretches.
  int send_quiet;
  int drain_quiet;

  sequential_keyed_list DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic skl_pkg::in_word_t make_word(logic [2:0] op, logic signed [31:0] key,
                                                  logic [31:0] payload, logic [6:0] pos);
    skl_pkg::in_word_t w;
    w.op            = op;
    w.entry_key     = key;
    w.entry_payload = payload;
    w.position      = pos;
    return w;
  endfunction

  // Keys are often drawn from a tiny pool so that ordered inserts meet equal keys and
  // removals by key find duplicates. Some are copied from the list so a removal hits,
  // and the rest cover the extremes and the full 32-bit range.
  function automatic logic signed [31:0] pick_key();
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      v = $urandom_range(0, 8);
      return v - 4;
    end
    if (r < 6 && list_model.n > 0) return list_model.keys[$urandom_range(0, list_model.n - 1)];
    if (r == 6) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $urandom;
  endfunction

  // Reads mostly target a valid position; the others cover zero, positions past the
  // count and every bit of the position field.
  function automatic logic [6:0] pick_position();
    if (list_model.n > 0 && $urandom_range(0, 9) < 7) begin
      return 7'($urandom_range(1, list_model.n));
    end
    return 7'($urandom_range(0, 127));
  endfunction

  // Growth phases lean hard on inserts so that the list fills up and inserts then fail.
  // Shrink phases do the same toward empty. Churn phases keep the size wandering.
  function automatic logic [2:0] pick_op(phase_kind_t phase);
    int r;
    int grow_pct;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_UNUSED;
    if (r < 20) return skl_pkg::OP_READ_POS;
    grow_pct = (phase == GROW) ? 95 : (phase == SHRINK) ? 5 : 50;
    if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       return skl_pkg::OP_INS_HEAD;
        1:       return skl_pkg::OP_INS_TAIL;
        default: return skl_pkg::OP_INS_ORD;
      endcase
    end
    case ($urandom_range(0, 3))
      0:       return skl_pkg::OP_RM_HEAD;
      1:       return skl_pkg::OP_RM_TAIL;
      default: return skl_pkg::OP_RM_KEY;
    endcase
  endfunction

  // Presents one request word after a random gap and holds it until the block takes it.
  // The model is updated on the very edge of acceptance.
  task automatic send_word(skl_pkg::in_word_t w);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    list_model.apply_request(w);
  endtask

  // Stops sending and waits until every pending response has come back.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (list_model.expected_words.size() != 0) @(posedge clk);
  endtask

  // Response side: stall a random number of cycles, then take one word and check it.
  initial begin : response_side
    int gap;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = draw_gap(drain_quiet);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      list_model.check_response(out_word);
    end
  end

  initial begin : request_side
    skl_pkg::in_word_t directed [$];
    phase_kind_t       phase;
    int                sent;
    int                span;
    in_valid <= 1'b0;
    in_word  <= '0;
    rst_n    <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Everything on an empty list must fail, the unused op code included.
    directed.push_back(make_word(skl_pkg::OP_READ_POS, 0, 0, 7'd1));
    directed.push_back(make_word(skl_pkg::OP_RM_HEAD, 0, 0, 7'd0));
    directed.push_back(make_word(skl_pkg::OP_RM_TAIL, 0, 0, 7'd0));
    directed.push_back(make_word(skl_pkg::OP_RM_KEY, 0, 0, 7'd0));
    directed.push_back(make_word(OP_UNUSED, -1, '1, '1));
    // Extreme keys and payloads at both ends, then ordered inserts into the middle and
    // onto keys equal to the smallest and the largest ones already held.
    directed.push_back(make_word(skl_pkg::OP_INS_TAIL, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 7'd0));
    directed.push_back(make_word(skl_pkg::OP_INS_HEAD, 32'sh8000_0000, 32'h0000_0000, 7'd0));
    directed.push_back(make_word(skl_pkg::OP_INS_ORD, 0, 32'hA5A5_5A5A, 7'd0));
    directed.push_back(make_word(skl_pkg::OP_INS_ORD, -1, 32'h5A5A_A5A5, 7'd0));
    directed.push_back(make_word(skl_pkg::OP_INS_ORD, 32'sh8000_0000, 32'h1111_1111, 7'd0));
    directed.push_back(make_word(skl_pkg::OP_INS_ORD, 32'sh7FFF_FFFF, 32'h2222_2222, 7'd0));
    // Reads at position zero, at the ends, one past the count and at the field maximum.
    directed.push_back(make_word(skl_pkg::OP_READ_POS, 0, 0, 7'd0));
    directed.push_back(make_word(skl_pkg::OP_READ_POS, 0, 0, 7'd1));
    directed.push_back(make_word(skl_pkg::OP_READ_POS, 0, 0, 7'd6));
    directed.push_back(make_word(skl_pkg::OP_READ_POS, 0, 0, 7'd7));
    directed.push_back(make_word(skl_pkg::OP_READ_POS, 0, 0, 7'd127));
    // Removal of an absent key, a key in the middle, and one held twice.
    directed.push_back(make_word(skl_pkg::OP_RM_KEY, 12345, 0, 7'd0));
    directed.push_back(make_word(skl_pkg::OP_RM_KEY, 0, 0, 7'd0));
    directed.push_back(make_word(skl_pkg::OP_RM_KEY, 32'sh8000_0000, 0, 7'd0));
    directed.push_back(make_word(skl_pkg::OP_READ_POS, 0, 0, 7'd1));
    directed.push_back(make_word(skl_pkg::OP_RM_HEAD, 0, 0, 7'd0));
    directed.push_back(make_word(skl_pkg::OP_RM_TAIL, 0, 0, 7'd0));
    directed.push_back(make_word(OP_UNUSED, 0, 0, 7'd1));
    directed.push_back(make_word(skl_pkg::OP_READ_POS, 0, 0, 7'd2));
    foreach (directed[i]) send_word(directed[i]);

    // Let the block go fully idle once before the random traffic starts.
    wait_until_drained();

    // The first two phases are long enough to fill the list and then empty it again.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent == 0) begin
        phase = GROW;
        span  = 110;
      end else if (sent == 110) begin
        phase = SHRINK;
        span  = 110;
      end else begin
        phase = phase_kind_t'($urandom_range(0, 2));
        span  = $urandom_range(30, 90);
        if ($urandom_range(0, 3) == 0) wait_until_drained();
      end
      for (int j = 0; j < span && sent < RANDOM_WORDS; j++) begin
        send_word(make_word(pick_op(phase), pick_key(), $urandom, pick_position()));
        sent++;
      end
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (list_model.fails == 0 && list_model.expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Ends the run as failed if it is still going when the watchdog delay runs out.
  initial begin : watchdog
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
